@@ src/bsl_pkg.sv @@
// shared types and constants for the backtracking step ladder
package bsl_pkg;

  localparam int STEP_FRAC_BITS = 16;
  localparam int STEP_W         = STEP_FRAC_BITS + 1;
  localparam int RATIO_W        = STEP_FRAC_BITS;
  localparam int RES_W          = 32;
  localparam int COUNT_W        = 8;
  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 32;

  localparam logic [STEP_W-1:0]  STEP_ONE      = STEP_W'(1) << STEP_FRAC_BITS;
  localparam logic [STEP_W-1:0]  FLOOR_DEFAULT = STEP_W'((2 ** STEP_FRAC_BITS + 500) / 1000);
  localparam logic [RATIO_W-1:0] RATIO_DEFAULT = RATIO_W'(2 ** (STEP_FRAC_BITS - 1));
  localparam logic [COUNT_W-1:0] BUDGET_DEFAULT = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TRIAL = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    DEC_CONTINUE  = 2'd0,
    DEC_ACCEPT    = 2'd1,
    DEC_EXHAUSTED = 2'd2
  } decision_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLOOR_STEP   = CFG_IDX_W'(0),
    REG_SHRINK_RATIO = CFG_IDX_W'(1),
    REG_TRIAL_BUDGET = CFG_IDX_W'(2),
    REG_LEGACY_MODE  = CFG_IDX_W'(3)
  } reg_idx_t;

  typedef struct packed {
    logic              kind;
    logic [STEP_W-1:0] first_step;
    logic [RES_W-1:0]  residual;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        decision;
    logic [STEP_W-1:0] next_step;
    logic [STEP_W-1:0] final_step;
  } out_word_t;

  typedef struct packed {
    logic [STEP_W-1:0]  floor_step;
    logic [RATIO_W-1:0] shrink_ratio;
    logic [COUNT_W-1:0] trial_budget;
    logic               legacy_mode;
  } cfg_t;

  typedef struct packed {
    logic [STEP_W-1:0]  step_now;
    logic [RES_W-1:0]   ref_res;
    logic [STEP_W-1:0]  best_step;
    logic [RES_W-1:0]   best_res;
    logic               have_best;
    logic [COUNT_W-1:0] trial_count;
    logic               contracted;
  } search_t;

endpackage

@@ src/bsl_cfg.sv @@
// configuration register bank for the step ladder
module bsl_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [bsl_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [bsl_pkg::CFG_DATA_W-1:0]  wr_data,
  output bsl_pkg::cfg_t                   cfg
);

  bsl_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.floor_step   <= bsl_pkg::FLOOR_DEFAULT;
      cfg_r.shrink_ratio <= bsl_pkg::RATIO_DEFAULT;
      cfg_r.trial_budget <= bsl_pkg::BUDGET_DEFAULT;
      cfg_r.legacy_mode  <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        bsl_pkg::REG_FLOOR_STEP:   cfg_r.floor_step   <= wr_data[bsl_pkg::STEP_W-1:0];
        bsl_pkg::REG_SHRINK_RATIO: cfg_r.shrink_ratio <= wr_data[bsl_pkg::RATIO_W-1:0];
        bsl_pkg::REG_TRIAL_BUDGET: cfg_r.trial_budget <= wr_data[bsl_pkg::COUNT_W-1:0];
        bsl_pkg::REG_LEGACY_MODE:  cfg_r.legacy_mode  <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/bsl_core.sv @@
// next search state and result word for one input word
module bsl_core (
  input  bsl_pkg::in_word_t  item,
  input  bsl_pkg::cfg_t      cfg,
  input  bsl_pkg::search_t   st,
  output bsl_pkg::search_t   st_nxt,
  output bsl_pkg::out_word_t res
);

  localparam int PROD_W = bsl_pkg::STEP_W + bsl_pkg::RATIO_W;

  logic [bsl_pkg::STEP_W-1:0]  flr;
  logic [bsl_pkg::RATIO_W-1:0] ratio;
  logic [bsl_pkg::COUNT_W-1:0] budget;
  logic [PROD_W-1:0]           prod;
  logic [bsl_pkg::STEP_W-1:0]  shrunk;
  logic [bsl_pkg::COUNT_W-1:0] count_inc;
  bsl_pkg::decision_t          dec;

  always_comb begin
    if (cfg.floor_step == '0) begin
      flr = bsl_pkg::FLOOR_DEFAULT;
    end else if (cfg.floor_step > bsl_pkg::STEP_ONE) begin
      flr = bsl_pkg::STEP_ONE;
    end else begin
      flr = cfg.floor_step;
    end
    ratio  = (cfg.shrink_ratio == '0) ? bsl_pkg::RATIO_DEFAULT : cfg.shrink_ratio;
    budget = (cfg.trial_budget == '0) ? bsl_pkg::BUDGET_DEFAULT : cfg.trial_budget;
  end

  // truncating fixed point product, then raised to the floor
  assign prod   = PROD_W'(st.step_now) * PROD_W'(ratio);
  assign shrunk = prod[bsl_pkg::STEP_FRAC_BITS +: bsl_pkg::STEP_W];

  assign count_inc = (st.trial_count < bsl_pkg::COUNT_MAX) ?
                     st.trial_count + bsl_pkg::COUNT_W'(1) : st.trial_count;

  always_comb begin
    st_nxt = st;
    dec    = bsl_pkg::DEC_CONTINUE;
    if (item.kind == bsl_pkg::KIND_START) begin
      if (item.first_step == '0 || item.first_step > bsl_pkg::STEP_ONE) begin
        st_nxt.step_now = bsl_pkg::STEP_ONE;
      end else begin
        st_nxt.step_now = item.first_step;
      end
      st_nxt.ref_res     = item.residual;
      st_nxt.best_step   = '0;
      st_nxt.best_res    = '0;
      st_nxt.have_best   = 1'b0;
      st_nxt.trial_count = '0;
      st_nxt.contracted  = 1'b0;
    end else begin
      st_nxt.trial_count = count_inc;
      // a tie with the best residual keeps the older step
      if (!st.have_best || item.residual < st.best_res) begin
        st_nxt.best_step = st.step_now;
        st_nxt.best_res  = item.residual;
        st_nxt.have_best = 1'b1;
      end
      if (item.residual <= st.ref_res) begin
        st_nxt.contracted = 1'b1;
        dec = bsl_pkg::DEC_ACCEPT;
      end else if (count_inc >= budget) begin
        dec = bsl_pkg::DEC_EXHAUSTED;
      end else if (st.step_now <= flr) begin
        dec = bsl_pkg::DEC_EXHAUSTED;
      end else if (count_inc == budget - bsl_pkg::COUNT_W'(1)) begin
        // last rung goes straight to the floor
        st_nxt.step_now = flr;
      end else begin
        st_nxt.step_now = (shrunk < flr) ? flr : shrunk;
      end
    end
  end

  always_comb begin
    res.decision  = dec;
    res.next_step = st_nxt.step_now;
    if (st_nxt.contracted || cfg.legacy_mode) begin
      res.final_step = st_nxt.step_now;
    end else if (st_nxt.have_best) begin
      res.final_step = st_nxt.best_step;
    end else begin
      res.final_step = st_nxt.step_now;
    end
  end

endmodule

@@ src/backtracking_step_ladder.sv @@
// top level of the backtracking step ladder: input stage, search state, result stage
//
//   channel  direction  handshake                 word
//   in_      in         in_valid / in_ready       bsl_pkg::in_word_t
//   out_     out        out_valid / out_ready     bsl_pkg::out_word_t
//   cfg_     in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one word per cycle sustained while out_ready is high; a word passes the input register, then the result register
// the search state is updated as a word leaves the input register, so the next word
// sees it through the combinational core (one 17x16 multiply, compares)
// reset loads the register defaults and a fresh search at step 1.0, both stages empty
// with out_ready low the result holds, one more word fills the input register, then
// in_ready drops; cfg_ready is always high
module backtracking_step_ladder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bsl_pkg::in_word_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bsl_pkg::out_word_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bsl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bsl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bsl_pkg::cfg_t      cfg;
  bsl_pkg::in_word_t  item_r;
  logic               item_vld_r;
  bsl_pkg::search_t   st_r;
  bsl_pkg::search_t   st_nxt;
  bsl_pkg::out_word_t res_nxt;
  bsl_pkg::out_word_t res_r;
  logic               res_vld_r;
  logic               advance;

  assign cfg_ready = 1'b1;

  bsl_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bsl_core u_core (
    .item   (item_r),
    .cfg    (cfg),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // result stage can take a word when empty or being drained
  assign advance  = !res_vld_r || out_ready;
  assign in_ready = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.step_now    <= bsl_pkg::STEP_ONE;
      st_r.ref_res     <= '0;
      st_r.best_step   <= '0;
      st_r.best_res    <= '0;
      st_r.have_best   <= 1'b0;
      st_r.trial_count <= '0;
      st_r.contracted  <= 1'b0;
    end else if (item_vld_r && advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_vld_r && advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

`ifndef SYNTH
  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.step_now != '0 && st_r.step_now <= bsl_pkg::STEP_ONE)
    else $error("current step out of range");

  a_accept_latched: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r && res_r.decision == bsl_pkg::DEC_ACCEPT |-> st_r.contracted)
    else $error("accepted result without latched contraction");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> item_vld_r && res_vld_r && !out_ready)
    else $error("input stalled with room in the pipeline");

  a_best_after_trial: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.trial_count == '0 |-> !st_r.have_best && !st_r.contracted)
    else $error("best or contraction set before any trial");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(item_vld_r && advance) |=> $stable(st_r))
    else $error("search state moved without a word");
`endif

endmodule
